// ===== hw/rtl/cma_pkg.sv =====
// Shared constants, width helpers and the front-end state type for the
// centered moving average core. No dependencies.
package cma_pkg;

  localparam int unsigned DEF_MAX_HALF_WINDOW = 16;
  localparam int unsigned DEF_SAMPLE_BITS     = 20;
  localparam int unsigned HALF_WINDOW_BITS    = 5;
  localparam int unsigned QUEUE_DEPTH         = 4;
  localparam int unsigned APB_ADDR_BITS       = 3;
  localparam int unsigned APB_DATA_BITS       = 32;

  // word index of the half-window register
  localparam logic [APB_ADDR_BITS-3:0] REG_HALF_WINDOW = '0;

  typedef enum logic {
    FRONT_RUN,
    FRONT_FLUSH
  } front_state_e;

  // running sum of up to 2*maxh+1 samples
  function automatic int unsigned sum_bits(int unsigned maxh, int unsigned sb);
    return sb + $clog2(2 * maxh + 1);
  endfunction

  // window length 2h+1, also the saturating bin count
  function automatic int unsigned div_bits(int unsigned maxh);
    return $clog2(2 * maxh + 2);
  endfunction

endpackage

// ===== hw/rtl/cma_front.sv =====
// Front end: takes bins, keeps the window and center delay lines and the
// running sum, and pushes dividend/divisor jobs. Depends on cma_pkg.
module cma_front import cma_pkg::*; #(
  parameter int unsigned MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  localparam int unsigned SumBits        = sum_bits(MAX_HALF_WINDOW, SAMPLE_BITS),
  localparam int unsigned CntBits        = div_bits(MAX_HALF_WINDOW)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [HALF_WINDOW_BITS-1:0] half_window_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic                        last_in_i,
  output logic                        push_o,
  output logic [SumBits-1:0]          push_dividend_o,
  output logic [CntBits-1:0]          push_divisor_o,
  output logic                        push_last_o,
  input  logic                        full_i
);

  localparam int unsigned FDepth   = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned CDepth   = MAX_HALF_WINDOW;
  localparam int unsigned HBits    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned FIdxBits = $clog2(FDepth);

  front_state_e state_q, state_d;

  logic [HBits-1:0]       active_h_q, fl_q;
  logic [SumBits-1:0]     sum_q;
  logic [CntBits-1:0]     seen_q;
  logic [SAMPLE_BITS-1:0] f_q [FDepth];
  logic [FDepth-1:0]      fv_q, fv_d;
  logic [SAMPLE_BITS-1:0] c_q [CDepth];
  logic [CDepth-1:0]      cv_q, cv_d;

  logic [HBits-1:0]       h_cfg, h_cur;
  logic [FIdxBits-1:0]    ins_f;
  logic [HBits-1:0]       ins_c;
  logic                   accept, flush_step, c_shift;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SumBits-1:0]     sum_new;
  logic [CntBits-1:0]     win;
  logic                   emit, pass;

  assign h_cfg = (32'(half_window_i) > MAX_HALF_WINDOW) ? HBits'(MAX_HALF_WINDOW)
                                                        : HBits'(half_window_i);
  assign h_cur = (state_q == FRONT_RUN && seen_q == '0) ? h_cfg : active_h_q;

  // insertion points so that each line's oldest entry sits at its far end
  assign ins_f = FIdxBits'(2 * MAX_HALF_WINDOW) - FIdxBits'({h_cur, 1'b0});
  assign ins_c = HBits'(MAX_HALF_WINDOW) - h_cur;

  assign in_ready_o = (state_q == FRONT_RUN) && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign flush_step = (state_q == FRONT_FLUSH) && !full_i;
  assign c_shift    = accept || flush_step;

  assign old_val = fv_q[FDepth-1] ? f_q[FDepth-1] : '0;
  assign sum_new = sum_q - SumBits'(old_val) + SumBits'(sample_i);
  assign win     = CntBits'({h_cur, 1'b1});
  assign emit    = seen_q >= CntBits'(h_cur);
  assign pass    = seen_q < CntBits'({h_cur, 1'b0});

  always_comb begin
    state_d         = state_q;
    push_o          = 1'b0;
    push_dividend_o = SumBits'(c_q[CDepth-1]);
    push_divisor_o  = CntBits'(1);
    push_last_o     = 1'b0;
    case (state_q)
      FRONT_RUN: begin
        push_o = accept && emit;
        if (!pass) begin
          push_dividend_o = sum_new;
          push_divisor_o  = win;
        end
        push_last_o = last_in_i && (h_cur == '0);
        if (accept && last_in_i && h_cur != '0) begin
          state_d = FRONT_FLUSH;
        end
      end
      FRONT_FLUSH: begin
        push_o      = flush_step && cv_q[CDepth-1];
        push_last_o = (fl_q == HBits'(1));
        if (flush_step && fl_q == HBits'(1)) begin
          state_d = FRONT_RUN;
        end
      end
      default: begin
        state_d = FRONT_RUN;
      end
    endcase
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      if (last_in_i) begin
        fv_d = '0;
      end else begin
        fv_d[0] = (ins_f == '0);
        for (int j = 1; j < FDepth; j++) begin
          fv_d[j] = (ins_f == FIdxBits'(j)) || fv_q[j-1];
        end
      end
    end
  end

  always_comb begin
    cv_d = cv_q;
    if (c_shift) begin
      cv_d[0] = accept && (ins_c == '0);
      for (int j = 1; j < CDepth; j++) begin
        cv_d[j] = (accept && ins_c == HBits'(j)) || cv_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FRONT_RUN;
      active_h_q <= '0;
      fl_q       <= '0;
      sum_q      <= '0;
      seen_q     <= '0;
      fv_q       <= '0;
      cv_q       <= '0;
    end else begin
      state_q <= state_d;
      fv_q    <= fv_d;
      cv_q    <= cv_d;
      if (accept) begin
        active_h_q <= h_cur;
        if (last_in_i) begin
          sum_q  <= '0;
          seen_q <= '0;
          fl_q   <= h_cur;
        end else begin
          sum_q <= sum_new;
          if (seen_q < win) begin
            seen_q <= seen_q + CntBits'(1);
          end
        end
      end else if (flush_step) begin
        fl_q <= fl_q - HBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q[0] <= sample_i;
      for (int j = 1; j < FDepth; j++) begin
        f_q[j] <= (ins_f == FIdxBits'(j)) ? sample_i : f_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_shift) begin
      c_q[0] <= sample_i;
      for (int j = 1; j < CDepth; j++) begin
        c_q[j] <= (ins_c == HBits'(j)) ? sample_i : c_q[j-1];
      end
    end
  end

endmodule

// ===== hw/rtl/cma_queue.sv =====
// Small job queue between the front end and the divider pipeline.
// Depends on cma_pkg for the default depth.
module cma_queue import cma_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrBits = $clog2(DEPTH);
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrBits'(DEPTH - 1)) ? '0 : wptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrBits'(DEPTH - 1)) ? '0 : rptr_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/cma_divider.sv =====
// Back end: restoring divider, one quotient bit per pipeline stage, then an
// output register. Depends on cma_pkg for the width helpers.
module cma_divider import cma_pkg::*; #(
  parameter int unsigned MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  localparam int unsigned SumBits        = sum_bits(MAX_HALF_WINDOW, SAMPLE_BITS),
  localparam int unsigned DivBits        = div_bits(MAX_HALF_WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SumBits-1:0]     in_dividend_i,
  input  logic [DivBits-1:0]     in_divisor_i,
  input  logic                   in_last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] value_o,
  output logic                   last_out_o
);

  localparam int unsigned Stages = SumBits;

  logic [Stages-1:0]  st_v_q;
  logic [DivBits-1:0] st_rem_q  [Stages];
  logic [DivBits-1:0] st_div_q  [Stages];
  logic [SumBits-1:0] st_qd_q   [Stages];
  logic               st_last_q [Stages];

  logic                   out_valid_q, out_last_q;
  logic [SAMPLE_BITS-1:0] out_value_q;
  logic                   adv;

  // whole pipeline moves together
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic               src_v, src_last, ge;
    logic [DivBits-1:0] src_rem, src_div, rem_n;
    logic [SumBits-1:0] src_qd;
    logic [DivBits:0]   trial, diff;

    if (i == 0) begin : g_first
      assign src_v    = in_valid_i;
      assign src_rem  = '0;
      assign src_div  = in_divisor_i;
      assign src_qd   = in_dividend_i;
      assign src_last = in_last_i;
    end else begin : g_next
      assign src_v    = st_v_q[i-1];
      assign src_rem  = st_rem_q[i-1];
      assign src_div  = st_div_q[i-1];
      assign src_qd   = st_qd_q[i-1];
      assign src_last = st_last_q[i-1];
    end

    assign trial = {src_rem, src_qd[SumBits-1]};
    assign diff  = trial - {1'b0, src_div};
    assign ge    = trial >= {1'b0, src_div};
    assign rem_n = ge ? diff[DivBits-1:0] : trial[DivBits-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[i] <= 1'b0;
      end else if (adv) begin
        st_v_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_rem_q[i]  <= rem_n;
        st_div_q[i]  <= src_div;
        st_qd_q[i]   <= {src_qd[SumBits-2:0], ge};
        st_last_q[i] <= src_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_v_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q <= st_qd_q[Stages-1][SAMPLE_BITS-1:0];
      out_last_q  <= st_last_q[Stages-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign last_out_o  = out_last_q;

endmodule

// ===== hw/rtl/centered_moving_average_core.sv =====
// Centered moving average core: APB register, front end, job queue and
// divider pipeline. Depends on cma_pkg, cma_front, cma_queue, cma_divider.
//
// Usage: bins enter on the in channel (sample_i, last_in_i marks the last
// bin of a track) and leave on the out channel in input order, same count,
// last_out_o on the final result of a track. Interior bins come out as the
// truncated mean of their 2h+1 centered neighbors; the first h and last h
// bins of a track, and every bin of a track of 2h bins or fewer, pass through.
// h comes from the half_window register (word 0, saturates at
// MAX_HALF_WINDOW) and is sampled on the first bin of each track.
// Throughput: one bin per cycle within a track while the job queue has room.
// The last bin of a track holds off the input while the center delay line
// drains, one held bin per cycle while the queue has room. A queued job
// passes the divider pipeline, one quotient bit per stage, then its output
// register; interior bins are held back h bins in the delay line before that.
// Reset clears the register to 0 and empties the lines, queue and pipeline.
// While a result waits and out_ready_i is low the divider pipeline holds; the
// four-entry queue keeps absorbing jobs, then in_ready_o drops until the output drains.
module centered_moving_average_core import cma_pkg::*; #(
  parameter int unsigned MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic                     last_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SAMPLE_BITS-1:0]   value_o,
  output logic                     last_out_o
);

  localparam int unsigned SumBits = sum_bits(MAX_HALF_WINDOW, SAMPLE_BITS);
  localparam int unsigned DivBits = div_bits(MAX_HALF_WINDOW);
  localparam int unsigned JobBits = SumBits + DivBits + 1;

  logic [HALF_WINDOW_BITS-1:0] half_window_q;
  logic                        reg_sel;

  logic               push, push_last, q_full, q_valid, q_pop;
  logic [SumBits-1:0] push_dividend;
  logic [DivBits-1:0] push_divisor;
  logic [JobBits-1:0] q_data;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_HALF_WINDOW);
  assign prdata  = reg_sel ? APB_DATA_BITS'(half_window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      half_window_q <= pwdata[HALF_WINDOW_BITS-1:0];
    end
  end

  cma_front #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .half_window_i  (half_window_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .last_in_i      (last_in_i),
    .push_o         (push),
    .push_dividend_o(push_dividend),
    .push_divisor_o (push_divisor),
    .push_last_o    (push_last),
    .full_i         (q_full)
  );

  cma_queue #(
    .WIDTH(JobBits),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_dividend, push_divisor, push_last}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  cma_divider #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_pop),
    .in_dividend_i(q_data[JobBits-1:DivBits+1]),
    .in_divisor_i (q_data[DivBits:1]),
    .in_last_i    (q_data[0]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .last_out_o   (last_out_o)
  );

endmodule

// ===== sim/centered_moving_average_core_test.sv =====
// Self-checking testbench for centered_moving_average_core: directed table then random
// tracks, results compared against an in-bench smoothing predictor.
// Depends on cma_pkg and the core RTL only.
module centered_moving_average_core_test import cma_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB = DEF_SAMPLE_BITS;
  localparam int unsigned MAXH = DEF_MAX_HALF_WINDOW;
  localparam int unsigned SUM_W = SB + 6;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam logic [APB_ADDR_BITS-1:0] HW_ADDR = {REG_HALF_WINDOW, 2'b00};
  localparam int DIR_N = 24;
  localparam int PHASES = 8;
  localparam int PHASE_BINS = 22;

  typedef enum logic {
    ROW_BIN,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] data;
    logic        last;
    logic        typed;
    logic [SB-1:0] exp_value;
    logic        exp_last;
  } bin_row_t;

  typedef struct packed {
    logic [SB-1:0] value;
    logic          last;
  } bin_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [SB-1:0] sample_i = '0;
  logic last_in_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SB-1:0] value_o;
  logic last_out_o;

  centered_moving_average_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .last_in_i  (last_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .last_out_o (last_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // smoothing state mirrored from the block
  logic [SB-1:0]    line_q [2*MAXH+1];
  logic [SUM_W-1:0] line_sum;
  int unsigned      bins_seen;
  int unsigned      track_h;
  logic [4:0]       hw_reg;
  logic [SB-1:0]    step_vals [2*MAXH+2];
  int               step_n;

  bin_out_t bins_due[$];
  int mismatches = 0;
  bit rx_eager = 1'b0;
  bit tx_eager = 1'b0;
  bit hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int rx_hold = 0;
  int rx_roll;

  bin_row_t dir_rows [DIR_N] = '{
    '{ROW_BIN, 32'h000F_FFFF, 1'b0, 1'b1, 20'hFFFFF, 1'b0},
    '{ROW_BIN, 32'h0000_0000, 1'b1, 1'b1, 20'h00000, 1'b1},
    '{ROW_BIN, 32'h0005_A5A5, 1'b1, 1'b1, 20'h5A5A5, 1'b1},
    '{ROW_CFG, 32'hFFFF_FFFF, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h000F_FFFF, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0000, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h000A_AAAA, 1'b1, 1'b0, 20'h0, 1'b0},
    '{ROW_CFG, 32'h0000_0001, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0001_2345, 1'b1, 1'b1, 20'h12345, 1'b1},
    '{ROW_BIN, 32'h000F_FFFF, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h000F_FFFF, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h000F_FFFF, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0000, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0001, 1'b1, 1'b0, 20'h0, 1'b0},
    '{ROW_CFG, 32'h0000_0002, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0010, 1'b0, 1'b0, 20'h0, 1'b0},
    // h changes mid-track; the track keeps h=2
    '{ROW_CFG, 32'h0000_0000, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0020, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0030, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0040, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0050, 1'b0, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0000_0060, 1'b1, 1'b0, 20'h0, 1'b0},
    '{ROW_BIN, 32'h0001_1111, 1'b0, 1'b1, 20'h11111, 1'b0},
    '{ROW_BIN, 32'h0002_2222, 1'b1, 1'b1, 20'h22222, 1'b1}
  };

  logic [31:0] phase_cfg [PHASES] = '{
    32'h0000_0010, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFF4,
    32'h0000_0001, 32'h0000_0003, 32'h0000_0008, 32'h0000_0000
  };

  function automatic void smooth_bin(input logic [SB-1:0] x, input logic last);
    int unsigned h, w, k, top;
    step_n = 0;
    if (bins_seen == 0) track_h = (hw_reg > MAXH) ? MAXH : hw_reg;
    h = track_h;
    w = 2 * h + 1;
    line_sum = line_sum - line_q[2*h];
    for (int i = 2 * h; i > 0; i--) line_q[i] = line_q[i-1];
    line_q[0] = x;
    line_sum = line_sum + x;
    k = bins_seen;
    if (k >= h) begin
      step_vals[step_n] = (k < 2 * h) ? line_q[h] : SB'(line_sum / SUM_W'(w));
      step_n++;
    end
    if (bins_seen < w) bins_seen++;
    if (last) begin
      if (h > 0) begin
        top = (k < h - 1) ? k : h - 1;
        for (int i = top + 1; i > 0; i--) begin
          step_vals[step_n] = line_q[i-1];
          step_n++;
        end
      end
      foreach (line_q[i]) line_q[i] = '0;
      line_sum = '0;
      bins_seen = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_eager || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return SB'($urandom);
  endfunction

  task automatic send_bin(input logic [SB-1:0] x, input logic last, input logic typed,
                          input bin_out_t typed_out);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= x;
    last_in_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    smooth_bin(x, last);
    if (typed) bins_due.push_back(typed_out);
    else
      for (int i = 0; i < step_n; i++)
        bins_due.push_back('{value: step_vals[i], last: last && (i == step_n - 1)});
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_window(input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HW_ADDR;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    hw_reg = data[4:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_BITS'(data[4:0])) begin
      $display("%0t: half_window readback mismatch, expected %h, actual %h",
               $time, APB_DATA_BITS'(data[4:0]), prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reconfigure(input logic [31:0] data);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_half_window(data);
  endtask

  task automatic check_result(input logic [SB-1:0] v, input logic l);
    bin_out_t e;
    if (bins_due.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual value %h last %b",
               $time, v, l);
      mismatches++;
    end else begin
      e = bins_due.pop_front();
      if (v !== e.value) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, e.value, v);
        mismatches++;
      end
      if (l !== e.last) begin
        $display("%0t: last_out mismatch, expected %b, actual %b", $time, e.last, l);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(value_o, last_out_o);
      if (!long_hold_done && hold_req) begin
        long_hold_done = 1'b1;
        rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_eager) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 70) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          rx_hold = (rx_roll < 97) ? $urandom_range(0, 2) : $urandom_range(15, 40);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase_bins, len, hh;
    bit paused;
    foreach (line_q[i]) line_q[i] = '0;
    line_sum = '0;
    bins_seen = 0;
    track_h = 0;
    hw_reg = '0;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) reconfigure(dir_rows[r].data);
      else send_bin(dir_rows[r].data[SB-1:0], dir_rows[r].last, dir_rows[r].typed,
                    '{value: dir_rows[r].exp_value, last: dir_rows[r].exp_last});
    end

    phase_cfg[PHASES-1] = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      reconfigure(phase_cfg[p]);
      rx_eager = (p == 2);
      tx_eager = (p == 4);
      // long receiver stall while the sender keeps streaming
      if (p == 4) hold_req = 1'b1;
      hh = (phase_cfg[p][4:0] > MAXH) ? MAXH : phase_cfg[p][4:0];
      phase_bins = 0;
      while (phase_bins < ((p == 4) ? 2 * PHASE_BINS : PHASE_BINS)) begin
        if (hh > 0 && $urandom_range(0, 99) < 15) len = $urandom_range(1, 2 * hh);
        else len = $urandom_range(1, 2 * hh + 12);
        for (int j = 0; j < len; j++)
          send_bin(pick_sample(), j == len - 1, 1'b0, '0);
        phase_bins += len;
        if (p == 1 && !paused) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
